// File: rtl/hex_checksum_frame_receiver_defines.svh
// Assertion macros for the hex checksum frame receiver.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef HEX_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH
`define HEX_CHECKSUM_FRAME_RECEIVER_DEFINES_SVH

// Checks that cond implies expr in the same cycle.
`define HCFR_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Checks that cond implies expr in the following cycle.
`define HCFR_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/hcfr_pkg.sv
// Types, constants and the hex digit decoder of the hex checksum frame receiver.
// Depends on nothing; used by hex_checksum_frame_receiver and its testbench.
package hcfr_pkg;

	// Result event codes.
	typedef enum logic [2:0] {
		EV_STORED    = 3'd0,
		EV_ACCEPTED  = 3'd1,
		EV_MISMATCH  = 3'd2,
		EV_NOT_HEX   = 3'd3,
		EV_OVERFLOW  = 3'd4,
		EV_EMPTY     = 3'd5,
		EV_TOO_SHORT = 3'd6
	} event_code_t;

	// Field widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PLEN_W = 9;

	// Delimiter after reset: the dollar sign.
	localparam logic [BYTE_W-1:0] DEFAULT_DELIMITER = 8'h24;

	// ASCII limits of the hex digit ranges.
	localparam logic [BYTE_W-1:0] CHAR_0       = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9       = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LOWER_F = 8'h66;
	localparam logic [BYTE_W-1:0] LETTER_BASE  = 8'd10;

	// One decoded hex digit.
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Decodes one ASCII hex digit of either case.
	function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_digit_t             r;
		logic [BYTE_W-1:0]      diff;
		r    = '0;
		diff = '0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			diff = c - CHAR_0;
			r.ok = 1'b1;
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			diff = c - CHAR_UPPER_A + LETTER_BASE;
			r.ok = 1'b1;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
			diff = c - CHAR_LOWER_A + LETTER_BASE;
			r.ok = 1'b1;
		end
		r.value = diff[3:0];
		return r;
	endfunction

endpackage

// File: rtl/hex_checksum_frame_receiver.sv
// Top level of the hex checksum frame receiver: input register, frame state and result register.
// Depends on hcfr_pkg and hex_checksum_frame_receiver_defines.svh.
`include "hex_checksum_frame_receiver_defines.svh"

// Checks delimited frames whose last two bytes are an ASCII hex XOR checksum. Every accepted
// byte gives exactly one result item, which passes through the input register and then the
// result register. A throughput of one byte per clock is sustained while the result channel
// does not stall; the XOR, two-byte history and byte count are updated with each byte.
// Bytes other than the delimiter report "stored", or "overflow discard" when the count would
// reach FRAME_DEPTH. The delimiter reports accepted, mismatch, not hex, empty or too short and
// clears the frame. The input register and the result register let one more byte be taken
// while a result waits. The delimiter register may be written only while the block is idle.
module hex_checksum_frame_receiver #(
	parameter int unsigned FRAME_DEPTH = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_wr_en,
	input  logic [hcfr_pkg::BYTE_W-1:0]   cfg_wr_data,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hcfr_pkg::BYTE_W-1:0]   rx_byte,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_code,
	output logic [hcfr_pkg::PLEN_W-1:0]   payload_length,
	output logic [hcfr_pkg::BYTE_W-1:0]   received_checksum,
	output logic [hcfr_pkg::BYTE_W-1:0]   computed_checksum
);

	localparam int unsigned CountWidth = $clog2(FRAME_DEPTH);
	localparam int unsigned LenWidth   = (CountWidth > hcfr_pkg::PLEN_W) ?
		CountWidth : hcfr_pkg::PLEN_W;
	localparam logic [CountWidth-1:0] LastCount = CountWidth'(FRAME_DEPTH - 1);

	// Configuration and frame state.
	logic [hcfr_pkg::BYTE_W-1:0] delimiter_q;
	logic [hcfr_pkg::BYTE_W-1:0] xor_q;
	logic [hcfr_pkg::BYTE_W-1:0] newest_q;
	logic [hcfr_pkg::BYTE_W-1:0] older_q;
	logic [CountWidth-1:0]       byte_count_q;

	// Input register.
	logic                        valid_s1;
	logic [hcfr_pkg::BYTE_W-1:0] rx_byte_s1;

	// Result register.
	logic                        out_valid_q;
	hcfr_pkg::event_code_t       event_q;
	logic [hcfr_pkg::PLEN_W-1:0] plen_q;
	logic [hcfr_pkg::BYTE_W-1:0] rx_sum_q;
	logic [hcfr_pkg::BYTE_W-1:0] calc_sum_q;

	// Handshake control.
	logic advance;
	logic in_accept;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Combinational evaluation of the item in the input register.
	logic                        is_delim;
	logic                        hit_last;
	hcfr_pkg::hex_digit_t        hi_digit;
	hcfr_pkg::hex_digit_t        lo_digit;
	logic [hcfr_pkg::BYTE_W-1:0] payload_xor;
	logic [hcfr_pkg::BYTE_W-1:0] rx_value;
	logic [LenWidth-1:0]         len_full;
	hcfr_pkg::event_code_t       ev_d;
	logic [hcfr_pkg::PLEN_W-1:0] plen_d;
	logic [hcfr_pkg::BYTE_W-1:0] rx_sum_d;
	logic [hcfr_pkg::BYTE_W-1:0] calc_sum_d;
	logic                        load;

	assign load = valid_s1 && advance;

	always_comb begin
		is_delim    = (rx_byte_s1 == delimiter_q);
		hit_last    = (byte_count_q == LastCount);
		hi_digit    = hcfr_pkg::hex_decode(older_q);
		lo_digit    = hcfr_pkg::hex_decode(newest_q);
		payload_xor = xor_q ^ newest_q ^ older_q;
		rx_value    = {hi_digit.value, lo_digit.value};
		len_full    = LenWidth'(byte_count_q) - LenWidth'(2);
		ev_d        = hcfr_pkg::EV_STORED;
		plen_d      = '0;
		rx_sum_d    = '0;
		calc_sum_d  = '0;
		if (!is_delim) begin
			if (hit_last) begin
				ev_d = hcfr_pkg::EV_OVERFLOW;
			end
		end else if (byte_count_q == '0) begin
			ev_d = hcfr_pkg::EV_EMPTY;
		end else if (byte_count_q == CountWidth'(1)) begin
			ev_d = hcfr_pkg::EV_TOO_SHORT;
		end else begin
			plen_d     = len_full[hcfr_pkg::PLEN_W-1:0];
			calc_sum_d = payload_xor;
			if (hi_digit.ok && lo_digit.ok) begin
				rx_sum_d = rx_value;
				ev_d     = (rx_value == payload_xor) ? hcfr_pkg::EV_ACCEPTED :
					hcfr_pkg::EV_MISMATCH;
			end else begin
				ev_d = hcfr_pkg::EV_NOT_HEX;
			end
		end
	end

	// Delimiter register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= hcfr_pkg::DEFAULT_DELIMITER;
		end else if (cfg_wr_en) begin
			delimiter_q <= cfg_wr_data;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Frame state update: fold a byte in, or clear on overflow and on a delimiter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q        <= '0;
			newest_q     <= '0;
			older_q      <= '0;
			byte_count_q <= '0;
		end else if (load) begin
			if (is_delim || hit_last) begin
				xor_q        <= '0;
				newest_q     <= '0;
				older_q      <= '0;
				byte_count_q <= '0;
			end else begin
				xor_q        <= xor_q ^ rx_byte_s1;
				newest_q     <= rx_byte_s1;
				older_q      <= newest_q;
				byte_count_q <= byte_count_q + CountWidth'(1);
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			event_q    <= ev_d;
			plen_q     <= plen_d;
			rx_sum_q   <= rx_sum_d;
			calc_sum_q <= calc_sum_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_code        = event_q;
	assign payload_length    = plen_q;
	assign received_checksum = rx_sum_q;
	assign computed_checksum = calc_sum_q;

	// Assertions.
	`HCFR_ASSERT_NEXT(a_verdict_clears, load && is_delim,
		byte_count_q == '0 && xor_q == '0, "frame state not cleared after a delimiter")
	`HCFR_ASSERT_NEXT(a_overflow_clears, load && !is_delim && hit_last,
		byte_count_q == '0, "frame state not cleared after an overflow")
	`HCFR_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance,
		valid_s1 && $stable(rx_byte_s1), "held input item lost or changed")
	`HCFR_ASSERT_NOW(a_accept_match, out_valid_q && event_q == hcfr_pkg::EV_ACCEPTED,
		rx_sum_q == calc_sum_q, "accepted frame with unequal checksums")

endmodule

// File: test/hex_checksum_frame_receiver_test.sv
// Self-checking testbench for the hex checksum frame receiver.
// Depends on hcfr_pkg and hex_checksum_frame_receiver; it reads no files.
`timescale 1ns / 1ps

module hex_checksum_frame_receiver_test;

	localparam int unsigned FRAME_DEPTH  = 512;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 80;

	// One verdict of the receiver, as it appears on the result port.
	typedef struct packed {
		hcfr_pkg::event_code_t              ev;
		logic [hcfr_pkg::PLEN_W-1:0]        plen;
		logic [hcfr_pkg::BYTE_W-1:0]        rx_sum;
		logic [hcfr_pkg::BYTE_W-1:0]        calc_sum;
	} frame_verdict_t;

	// Receiver stall patterns.
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [hcfr_pkg::BYTE_W-1:0]   cfg_wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [hcfr_pkg::BYTE_W-1:0]   rx_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [2:0]                    event_code;
	logic [hcfr_pkg::PLEN_W-1:0]   payload_length;
	logic [hcfr_pkg::BYTE_W-1:0]   received_checksum;
	logic [hcfr_pkg::BYTE_W-1:0]   computed_checksum;

	// Expected verdicts, oldest first.
	frame_verdict_t                pending_verdicts[$];

	// Own copy of the frame state and the delimiter register.
	logic [hcfr_pkg::BYTE_W-1:0]   delim_reg;
	logic [hcfr_pkg::BYTE_W-1:0]   xor_acc;
	logic [hcfr_pkg::BYTE_W-1:0]   newest_byte;
	logic [hcfr_pkg::BYTE_W-1:0]   older_byte;
	int unsigned                   frame_bytes;

	int unsigned         mismatches;
	int unsigned         cycle_count;
	int unsigned         items_sent;
	int unsigned         burst_left;
	bit                  gaps_on;
	stall_mode_t         stall_mode;
	int unsigned         stall_left;

	hex_checksum_frame_receiver #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_code       (event_code),
		.payload_length   (payload_length),
		.received_checksum(received_checksum),
		.computed_checksum(computed_checksum)
	);

	// Clock with a 12 ns period.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Cycle counter that ends a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d verdicts outstanding",
				$time, pending_verdicts.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver stalls follow a pattern that is picked anew at random intervals.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(40, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= ((cycle_count % 7) < 3);
		endcase
	end

	// Decodes one ASCII hex digit of either case; returns 0 if it is none.
	function automatic logic hex_nibble(input logic [hcfr_pkg::BYTE_W-1:0] c,
		output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_frame();
		xor_acc     = '0;
		newest_byte = '0;
		older_byte  = '0;
		frame_bytes = 0;
	endfunction

	// Updates the frame state with one accepted byte and returns its verdict.
	function automatic frame_verdict_t fold_byte(input logic [hcfr_pkg::BYTE_W-1:0] b);
		frame_verdict_t               r;
		logic [hcfr_pkg::BYTE_W-1:0]  payload_xor;
		logic [3:0]                   hi;
		logic [3:0]                   lo;
		logic                         hi_ok;
		logic                         lo_ok;
		r    = '0;
		r.ev = hcfr_pkg::EV_STORED;
		if (b != delim_reg) begin
			older_byte  = newest_byte;
			newest_byte = b;
			xor_acc    ^= b;
			frame_bytes++;
			if (frame_bytes >= FRAME_DEPTH) begin
				clear_frame();
				r.ev = hcfr_pkg::EV_OVERFLOW;
			end
		end else begin
			if (frame_bytes == 0) begin
				r.ev = hcfr_pkg::EV_EMPTY;
			end else if (frame_bytes == 1) begin
				r.ev = hcfr_pkg::EV_TOO_SHORT;
			end else begin
				// The last two bytes are the checksum digits, not payload.
				payload_xor = xor_acc ^ newest_byte ^ older_byte;
				r.plen      = hcfr_pkg::PLEN_W'(frame_bytes - 2);
				r.calc_sum  = payload_xor;
				hi_ok       = hex_nibble(older_byte, hi);
				lo_ok       = hex_nibble(newest_byte, lo);
				if (hi_ok && lo_ok) begin
					r.rx_sum = {hi, lo};
					r.ev     = (r.rx_sum == payload_xor) ? hcfr_pkg::EV_ACCEPTED :
						hcfr_pkg::EV_MISMATCH;
				end else begin
					r.ev = hcfr_pkg::EV_NOT_HEX;
				end
			end
			clear_frame();
		end
		return r;
	endfunction

	// Compares every accepted result with the oldest expected verdict.
	task automatic check_field(input string label, input logic [15:0] exp, input logic [15:0] act);
		if (exp !== act) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, label, exp, act);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		frame_verdict_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t unexpected result: expected none, actual event %0d",
					$time, event_code);
				mismatches++;
			end else begin
				exp = pending_verdicts.pop_front();
				check_field("event_code", 16'(exp.ev), 16'(event_code));
				check_field("payload_length", 16'(exp.plen), 16'(payload_length));
				check_field("received_checksum", 16'(exp.rx_sum), 16'(received_checksum));
				check_field("computed_checksum", 16'(exp.calc_sum), 16'(computed_checksum));
			end
		end
	end

	// Sends one item, idling in random gaps between bursts when gaps are enabled.
	task automatic send_byte(input logic [hcfr_pkg::BYTE_W-1:0] b);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				rx_byte  <= hcfr_pkg::BYTE_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0)
			burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		pending_verdicts.push_back(fold_byte(b));
		items_sent++;
	endtask

	// Stops sending and waits until every expected verdict has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the delimiter register while the receiver is idle.
	task automatic set_delimiter(input logic [hcfr_pkg::BYTE_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= hcfr_pkg::BYTE_W'($urandom);
		delim_reg    = value;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// A random byte that does not end the frame.
	function automatic logic [hcfr_pkg::BYTE_W-1:0] payload_byte();
		logic [hcfr_pkg::BYTE_W-1:0] b;
		do b = hcfr_pkg::BYTE_W'($urandom); while (b == delim_reg);
		return b;
	endfunction

	// ASCII hex digit of a nibble, in a random case.
	function automatic logic [hcfr_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return "0" + n;
		return hcfr_pkg::BYTE_W'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
	endfunction

	task automatic send_checksum(input logic [hcfr_pkg::BYTE_W-1:0] sum);
		send_byte(hex_char(sum[7:4]));
		send_byte(hex_char(sum[3:0]));
	endtask

	// Sends a frame of random payload, mostly with a correct checksum.
	task automatic send_random_frame(input int unsigned payload_len);
		logic [hcfr_pkg::BYTE_W-1:0] sum;
		logic [hcfr_pkg::BYTE_W-1:0] b;
		int unsigned                 kind;
		sum = '0;
		for (int unsigned i = 0; i < payload_len; i++) begin
			b    = payload_byte();
			sum ^= b;
			send_byte(b);
		end
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			send_checksum(sum);
		end else if (kind <= 7) begin
			send_checksum(sum ^ hcfr_pkg::BYTE_W'($urandom_range(1, 255)));
		end else if (kind == 8) begin
			send_byte(payload_byte());
			send_byte(payload_byte());
		end
		send_byte(delim_reg);
	endtask

	// Random bytes with frequent delimiters, giving empty and short frames.
	task automatic send_noise(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_byte(($urandom_range(0, 5) == 0) ? delim_reg :
				hcfr_pkg::BYTE_W'($urandom));
	endtask

	// Empty, one-byte and checksum-only frames.
	task automatic test_short_frames();
		send_text("$");
		send_text("7$");
		send_text("00$");
		send_text("0f$");
	endtask

	// Both letter cases and the characters just outside each digit range.
	task automatic test_hex_digits();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("Ff$");
		send_text("/:$");
		send_text("@G$");
		send_text("9`$");
		send_text("g0$");
	endtask

	// A frame that grows up to the depth: the byte after the longest checksummed frame
	// that fits is discarded as an overflow, then a short frame follows.
	task automatic test_long_frames();
		logic [hcfr_pkg::BYTE_W-1:0] sum;
		logic [hcfr_pkg::BYTE_W-1:0] b;
		sum = '0;
		for (int unsigned i = 0; i < FRAME_DEPTH - 3; i++) begin
			b    = payload_byte();
			sum ^= b;
			send_byte(b);
		end
		send_checksum(sum);
		send_byte(payload_byte());
		send_random_frame(3);
	endtask

	// Random frames under the extreme delimiters, a hex digit and a newline.
	task automatic test_delimiter_settings();
		logic [hcfr_pkg::BYTE_W-1:0] settings[4];
		settings = '{8'h00, 8'hFF, "0", 8'h0A};
		foreach (settings[i]) begin
			set_delimiter(settings[i]);
			for (int j = 0; j < 2; j++)
				send_random_frame($urandom_range(0, 8));
			send_noise(5);
		end
		set_delimiter(hcfr_pkg::DEFAULT_DELIMITER);
	endtask

	// Mostly well-formed frames of random size, mixed with noise.
	task automatic test_random_traffic();
		int unsigned target;
		int unsigned pick;
		bit          paused;
		target = items_sent + RANDOM_ITEMS;
		paused = 1'b0;
		while (items_sent < target) begin
			// Hold the sender once until the receiver has caught up.
			if (!paused && items_sent >= target - RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 7) == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_random_frame($urandom_range(0, (pick == 0) ? 60 : 10));
			else
				send_noise($urandom_range(1, 12));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		rx_byte     = '0;
		out_stall   = 1'b0;
		mismatches  = 0;
		cycle_count = 0;
		items_sent  = 0;
		burst_left  = 0;
		gaps_on     = 1'b1;
		stall_mode  = STALL_NONE;
		stall_left  = 0;
		delim_reg   = hcfr_pkg::DEFAULT_DELIMITER;
		clear_frame();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_hex_digits();
		test_long_frames();
		test_delimiter_settings();
		test_random_traffic();

		drain_results();
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
